@@ src/hfsa_pkg.sv @@
// Shared constants and controller/datapath interface types for the slot allocator.
package hfsa_pkg;

    localparam int unsigned DEF_MAX_SLOTS = 1024;
    localparam int unsigned FIELD_W       = 11;
    localparam int unsigned MAP_WORD_W    = 32;
    localparam int unsigned BIT_IDX_W     = 5;
    localparam int unsigned SLOT_CAP      = 2047;
    localparam logic [FIELD_W-1:0] NUM_GATES_RESET = 11'd1024;
    localparam logic [FIELD_W-1:0] COUNT_MAX       = 11'd2047;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // take a new request and set up the scan
        logic rd_step;     // read the next lower map word
        logic commit_hit;  // mark the found slot used and count it
        logic commit_fail; // set the sticky halt flag
        logic out_load;    // move the result into the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;        // request needs no scan (halted or empty range)
        logic halted;      // sticky halt flag
        logic hit;         // the current map word holds a free slot in range
        logic last_word;   // the current map word is word zero
    } t_dp_status;

endpackage

@@ src/hfsa_ctrl.sv @@
// Controller state machine that sequences the downward scan of the free map.
module hfsa_ctrl
    import hfsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = (r_state == ST_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                if (i_status.skip) begin
                    o_cmd.commit_fail = !i_status.halted;
                    n_state           = ST_FINISH;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.hit) begin
                    o_cmd.commit_hit = 1'b1;
                    n_state          = ST_FINISH;
                end else if (i_status.last_word) begin
                    o_cmd.commit_fail = 1'b1;
                    n_state           = ST_FINISH;
                end else begin
                    o_cmd.rd_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ src/hfsa_datapath.sv @@
// Datapath: free-map memory, scan pointer, grant counter, halt flag and output register.
module hfsa_datapath
    import hfsa_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [FIELD_W-1:0] i_cfg_data,
    input  logic [FIELD_W-1:0] i_requested_limit,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_status         o_status,
    output logic [FIELD_W-1:0] o_granted_slot,
    output logic               o_granted,
    output logic [FIELD_W-1:0] o_grant_count,
    output logic               o_halted
);

    // Slot indices never exceed what the 11-bit slot count can reach.
    localparam int unsigned TOP_MAX = (MAX_SLOTS > SLOT_CAP) ? SLOT_CAP : MAX_SLOTS;
    localparam int unsigned WORDS   = TOP_MAX / MAP_WORD_W + 1;
    localparam int unsigned AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [FIELD_W-1:0] TOP_LIM = FIELD_W'(TOP_MAX);

    logic [MAP_WORD_W-1:0] r_map [WORDS];
    logic [WORDS-1:0]      r_word_valid;
    logic [MAP_WORD_W-1:0] r_rd_data;
    logic                  r_rd_valid;

    logic [FIELD_W-1:0]    r_num_gates;
    logic [FIELD_W-1:0]    r_count, n_count;
    logic                  r_stopped;
    logic                  r_skip;
    logic [AW-1:0]         r_word;
    logic [MAP_WORD_W-1:0] r_mask;
    logic [FIELD_W-1:0]    r_slot;

    logic [FIELD_W-1:0]    r_out_slot;
    logic [FIELD_W-1:0]    r_out_count;
    logic                  r_out_halted;

    logic [FIELD_W-1:0]    gates_clamped;
    logic [FIELD_W-1:0]    top;
    logic [AW-1:0]         rd_addr;
    logic [MAP_WORD_W-1:0] cur_word;
    logic [MAP_WORD_W-1:0] free_bits;
    logic [BIT_IDX_W-1:0]  hit_bit;
    logic [MAP_WORD_W-1:0] hit_onehot;

    function automatic logic [BIT_IDX_W-1:0] highest_set(input logic [MAP_WORD_W-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAP_WORD_W; i++) begin
            if (v[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        gates_clamped = (r_num_gates < TOP_LIM) ? r_num_gates : TOP_LIM;
        top           = (i_requested_limit < gates_clamped) ? i_requested_limit : gates_clamped;
        rd_addr       = i_cmd.rd_step ? (r_word - AW'(1)) : r_word;
        cur_word      = r_rd_valid ? r_rd_data : '0;
        free_bits     = ~cur_word & r_mask;
        if (r_word == '0) begin
            // Bit zero of word zero is slot zero, which is never a real slot.
            free_bits[0] = 1'b0;
        end
        hit_bit    = highest_set(free_bits);
        hit_onehot = MAP_WORD_W'(1) << hit_bit;
        n_count    = (r_count < COUNT_MAX) ? (r_count + FIELD_W'(1)) : r_count;
    end

    assign o_status.skip      = r_skip;
    assign o_status.halted    = r_stopped;
    assign o_status.hit       = |free_bits;
    assign o_status.last_word = (r_word == '0);

    // Map memory with registered read; per-word valid bits give the all-free reset.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_map[rd_addr];
        if (i_cmd.commit_hit) begin
            r_map[r_word] <= cur_word | hit_onehot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_rd_valid <= r_word_valid[rd_addr];
            if (i_cmd.commit_hit) begin
                r_word_valid[r_word] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_gates <= NUM_GATES_RESET;
            r_count     <= '0;
            r_stopped   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_gates <= i_cfg_data;
            end
            if (i_cmd.commit_hit) begin
                r_count <= n_count;
            end
            if (i_cmd.commit_fail) begin
                r_stopped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_skip <= r_stopped || (top == '0);
            r_word <= AW'(top[FIELD_W-1:BIT_IDX_W]);
            r_mask <= {MAP_WORD_W{1'b1}} >> (BIT_IDX_W'(MAP_WORD_W - 1) - top[BIT_IDX_W-1:0]);
            r_slot <= '0;
        end else if (i_cmd.rd_step) begin
            r_word <= r_word - AW'(1);
            r_mask <= {MAP_WORD_W{1'b1}};
        end
        if (i_cmd.commit_hit) begin
            r_slot <= FIELD_W'({r_word, hit_bit});
        end
        if (i_cmd.out_load) begin
            r_out_slot   <= r_slot;
            r_out_count  <= r_count;
            r_out_halted <= r_stopped;
        end
    end

    assign o_granted_slot = r_out_slot;
    assign o_granted      = (r_out_slot != '0);
    assign o_grant_count  = r_out_count;
    assign o_halted       = r_out_halted;

endmodule

@@ src/highest_free_slot_allocator_core.sv @@
// Top level of the highest-free-slot allocator: controller and datapath.
//
// Usage. Requests arrive on the input channel (i_in_valid / o_in_ready) as a beat
// carrying i_requested_limit. Each request yields exactly one result beat on the
// output channel (o_out_valid / i_out_ready): the granted slot (zero for no grant),
// a granted flag, the running grant count and the sticky halt flag.
// The slot count is written through the configuration channel (i_cfg_valid /
// o_cfg_ready, data i_cfg_data); it is always ready and should be written only
// while no request is in flight.
// Sequencing: a request is captured, its top map word is read, and the downward
// scan then evaluates one 32-bit word of the free map per cycle until it finds
// a free slot or passes word zero; the result is then loaded into the output
// register. Requests that need no scan (already halted, or an empty range) go
// straight to the result. One request is worked on at a time.
// Reset: the synchronous active-low reset frees every slot at once via per-word
// valid bits, clears the grant count and halt flag and sets the slot count to 1024.
// Stalls: the result sits in an output register; a new request is taken while it
// waits, and a second finished result waits in the controller until the
// receiver takes the first.
module highest_free_slot_allocator_core
    import hfsa_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [FIELD_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FIELD_W-1:0] i_requested_limit,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FIELD_W-1:0] o_granted_slot,
    output logic               o_granted,
    output logic [FIELD_W-1:0] o_grant_count,
    output logic               o_halted
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // The slot count register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    hfsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hfsa_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_requested_limit (i_requested_limit),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_granted_slot    (o_granted_slot),
        .o_granted         (o_granted),
        .o_grant_count     (o_grant_count),
        .o_halted          (o_halted)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the highest-free-slot allocator core.
`timescale 1ns / 1ps

module tb;
    import hfsa_pkg::*;

    // The allocator is built with its default slot capacity.
    localparam int SLOTS      = DEF_MAX_SLOTS;
    localparam int LIMIT_MAX  = (1 << FIELD_W) - 1;
    // Longest a request may take in the core, rounded up generously.
    localparam int SETTLE     = 40;
    // Cycles without any beat on any channel before the run is abandoned.
    localparam int STALL_LIMIT = 4000;

    // One result beat as the output channel presents it.
    typedef struct packed {
        logic [FIELD_W-1:0] slot;
        logic               granted;
        logic [FIELD_W-1:0] count;
        logic               halted;
    } t_grant;

    // Receiver behaviour, re-chosen at random by the output monitor.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_WINDOWED
    } t_stall_mode;

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_cfg_valid       = 1'b0;
    logic               o_cfg_ready;
    logic [FIELD_W-1:0] i_cfg_data        = '0;
    logic               i_in_valid        = 1'b0;
    logic               o_in_ready;
    logic [FIELD_W-1:0] i_requested_limit = '0;
    logic               o_out_valid;
    logic               i_out_ready       = 1'b0;
    logic [FIELD_W-1:0] o_granted_slot;
    logic               o_granted;
    logic [FIELD_W-1:0] o_grant_count;
    logic               o_halted;

    highest_free_slot_allocator_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_requested_limit (i_requested_limit),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_granted_slot    (o_granted_slot),
        .o_granted         (o_granted),
        .o_grant_count     (o_grant_count),
        .o_halted          (o_halted)
    );

    always #1 i_clk = ~i_clk;

    // Allocator state as the testbench believes it to be. Slot i lives at bit i;
    // bit 0 is never used, since slot 0 stands for "no grant".
    logic [SLOTS:0]     used_slots  = '0;
    logic [FIELD_W-1:0] slot_count  = NUM_GATES_RESET;
    logic [FIELD_W-1:0] grant_total = '0;
    logic               halt_seen   = 1'b0;

    // A second map, used only by the stimulus generator to steer requests
    // towards ones that succeed until the very end of the run.
    logic [SLOTS:0]     plan_used   = '0;

    logic [FIELD_W-1:0] pending_limits[$];
    t_grant             slot_grants[$];
    int                 items_in_flight = 0;
    int                 mismatches      = 0;

    int                 burst_left  = 0;
    int                 gap_left    = 0;
    int                 cycle_no    = 0;
    t_stall_mode        stall_mode  = READY_ALWAYS;
    int                 idle_cycles = 0;
    t_grant             got;
    t_grant             want;

    // Highest reachable slot for a request: the limit, but never above the
    // configured slot count, which itself is capped at the capacity.
    function automatic int reachable_top(input int gates, input int limit);
        int top;
        top = (gates > SLOTS) ? SLOTS : gates;
        if (limit < top) begin
            top = limit;
        end
        return top;
    endfunction

    // Downward search for the highest free slot at or below top; zero if none.
    function automatic int highest_free(input logic [SLOTS:0] map, input int top);
        int i;
        i = top;
        while (i > 0 && map[i]) begin
            i--;
        end
        return i;
    endfunction

    function automatic int lowest_free(input logic [SLOTS:0] map, input int top);
        for (int i = 1; i <= top; i++) begin
            if (!map[i]) begin
                return i;
            end
        end
        return 0;
    endfunction

    // Works out the result of one accepted request and moves the predicted
    // state on. Once halted, nothing changes but the request still answers.
    function automatic t_grant allocate_slot(input logic [FIELD_W-1:0] limit);
        t_grant g;
        int     s;
        g = '0;
        if (!halt_seen) begin
            s = highest_free(used_slots, reachable_top(slot_count, limit));
            if (s == 0) begin
                halt_seen = 1'b1;
            end else begin
                used_slots[s] = 1'b1;
                if (grant_total != COUNT_MAX) begin
                    grant_total = grant_total + 1'b1;
                end
                g.slot    = s[FIELD_W-1:0];
                g.granted = 1'b1;
            end
        end
        g.count  = grant_total;
        g.halted = halt_seen;
        return g;
    endfunction

    // Hands one request to the driver and keeps the planning map in step.
    task automatic queue_request(input int limit);
        int s;
        s = highest_free(plan_used, reachable_top(slot_count, limit));
        if (s != 0) begin
            plan_used[s] = 1'b1;
        end
        pending_limits = {pending_limits, limit[FIELD_W-1:0]};
        items_in_flight++;
    endtask

    // Waits until every result is back and the core has had time to settle,
    // then writes the slot count through the configuration channel.
    task automatic write_slot_count(input int value);
        while (items_in_flight != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[FIELD_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        slot_count  = value[FIELD_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    // Input driver. The sender works in bursts of random length separated by
    // random gaps; a gap of zero lets bursts run back to back. Every accepted
    // beat is run through the predictor straight away, so expectations queue
    // up in the order the core must answer them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            used_slots  = '0;
            slot_count  = NUM_GATES_RESET;
            grant_total = '0;
            halt_seen   = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                slot_grants = {slot_grants, allocate_slot(i_requested_limit)};
            end
            // The payload may only change once the current beat has gone.
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 || pending_limits.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid        <= 1'b1;
                    i_requested_limit <= pending_limits.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 1);
                    end
                end
            end
        end
    end

    // Output monitor. Each result beat is compared field by field with the
    // oldest expectation. The receiver switches between always ready, a coin
    // toss, sparse acceptance and a fixed window with long stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_granted_slot, o_granted, o_grant_count, o_halted};
                if (slot_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"%0t: unexpected result slot=%0d granted=%0d",
                                  " count=%0d halted=%0d"},
                                 $realtime, got.slot, got.granted, got.count, got.halted);
                    end
                end else begin
                    want = slot_grants.pop_front();
                    items_in_flight--;
                    if (got.slot !== want.slot || got.granted !== want.granted ||
                        got.count !== want.count || got.halted !== want.halted) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: mismatch slot %0d/%0d granted %0d/%0d",
                                      " count %0d/%0d halted %0d/%0d (expected/actual)"},
                                     $realtime, want.slot, got.slot, want.granted,
                                     got.granted, want.count, got.count, want.halted,
                                     got.halted);
                        end
                    end
                end
            end
            cycle_no++;
            if (cycle_no % 256 == 0) begin
                stall_mode = t_stall_mode'($urandom_range(3));
            end
            case (stall_mode)
                READY_ALWAYS:   i_out_ready <= 1'b1;
                READY_COIN:     i_out_ready <= 1'($urandom_range(1));
                READY_SPARSE:   i_out_ready <= ($urandom_range(3) == 0);
                READY_WINDOWED: i_out_ready <= (cycle_no % 24) < 6;
                default:        i_out_ready <= 1'b1;
            endcase
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("highest_free_slot_allocator_core verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus. Slots are never freed except by reset, and the first failed
    // request halts the core for good, so the run is laid out to keep every
    // request successful until the last phases, where failures are let in.
    initial begin
        int directed_limits[15];
        int phase_gates[6];
        int phase_items[6];
        int top;
        int low;
        int pick;
        int limit;

        directed_limits = '{1024, 2047, 2, 1025, 33, 32, 64, 63, 31, 3,
                            1365, 682, 33, 1024, 1000};
        phase_gates     = '{40, 1024, 300, 2047, 700, 1024};
        phase_items     = '{30, 250, 200, 200, 150, 400};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Slot count of one: only slot 1 exists, reached through a limit
        // far above it.
        write_slot_count(1);
        queue_request(LIMIT_MAX);

        // A slot count beyond the capacity is capped. The directed requests
        // hit the top slot, limits above the slot count, word boundaries of
        // the free map, rescans past used slots and alternating bit patterns.
        write_slot_count(LIMIT_MAX);
        foreach (directed_limits[k]) begin
            queue_request(directed_limits[k]);
        end

        // Random phases under a range of slot counts. Slots above a smaller
        // count stay used but out of reach; a phase stops early once its
        // range has no free slot left.
        for (int p = 0; p < 6; p++) begin
            write_slot_count(phase_gates[p]);
            top = reachable_top(slot_count, LIMIT_MAX);
            for (int n = 0; n < phase_items[p]; n++) begin
                low = lowest_free(plan_used, top);
                if (low == 0) begin
                    break;
                end
                pick = $urandom_range(9);
                if (pick < 6) begin
                    limit = $urandom_range(top, low);
                end else if (pick < 8) begin
                    limit = $urandom_range(LIMIT_MAX, top);
                end else begin
                    limit = low + $urandom_range(3);
                    if (limit > top) begin
                        limit = top;
                    end
                end
                queue_request(limit);
            end
        end

        // Noise, zero limits among it: the first request that finds nothing
        // free halts the core, and everything after it must be refused.
        for (int n = 0; n < 300; n++) begin
            queue_request(($urandom_range(4) == 0) ? 0 : $urandom_range(LIMIT_MAX, 0));
        end

        // No slots at all, then the full count again: the halt must hold.
        write_slot_count(0);
        for (int n = 0; n < 60; n++) begin
            queue_request($urandom_range(LIMIT_MAX, 0));
        end
        write_slot_count(SLOTS);
        for (int n = 0; n < 60; n++) begin
            queue_request($urandom_range(LIMIT_MAX, 0));
        end

        while (items_in_flight != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0 && slot_grants.size() == 0) begin
            $display("highest_free_slot_allocator_core verification clean");
        end else begin
            $display("highest_free_slot_allocator_core verification failed");
        end
        $finish;
    end

endmodule
